// ===== rtl/core/rce_pkg.sv =====
// rce_pkg: shared types and constants for the rank correlation engine
// holds request/response structs, memory word layout and rank-sum bundle
// no dependencies
`default_nettype none
package rce_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned SAMPLE_W       = 32;
  localparam int unsigned SUM_W          = 64;
  localparam int unsigned RHO_W          = 16;
  localparam int unsigned COUNT_OUT_W    = 11;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic                       last_pair;
  } req_t;

  typedef struct packed {
    logic signed [RHO_W-1:0]  rho;
    logic                     invalid;
    logic [COUNT_OUT_W-1:0]   pair_count;
  } rsp_t;

  // one memory word: a stored sample pair
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
  } pair_t;

  // rank sums handed from the ranking sequencer to the correlation unit
  typedef struct packed {
    logic [SUM_W-1:0] sxx;
    logic [SUM_W-1:0] syy;
    logic [SUM_W-1:0] sxy;
  } sums_t;

  // correlation result without the pair count
  typedef struct packed {
    logic signed [RHO_W-1:0] rho;
    logic                    invalid;
  } corr_t;

endpackage
`default_nettype wire

// ===== rtl/core/rank_correlation_engine_unit.sv =====
// rank_correlation_engine_unit: top level of the Spearman rank correlation engine
// loads pairs into rce_pair_mem, ranks with rce_rank_unit, finishes in rce_corr_unit
// depends on rce_pkg
//
//   channel  direction  handshake                 payload
//   in       request    in_valid_i / in_stall_o   in_req_i   (rce_pkg::req_t)
//   out      result     out_valid_o / out_stall_i out_rsp_o  (rce_pkg::rsp_t)
//
// pairs load one per cycle while the input is not stalled; the pair closing a set starts the computation
// ranking reads one compare pair per cycle on two memory read ports
// rho then follows in steps: product, square root, divide, round
// input stalls from the closing pair until its result enters the output register
// a finished result waits in the output register while the next set loads
// no clearing pass after reset: only entries written in the current set are read
`default_nettype none
module rank_correlation_engine_unit #(
  parameter int unsigned MAX_POINTS = rce_pkg::MAX_POINTS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire rce_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output rce_pkg::rsp_t      out_rsp_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0]  cnt_q, n_q, cnt_inc;
  logic           busy_q, start_q, out_valid_q;
  rce_pkg::rsp_t  out_q;

  logic           accept, wr_en, ld;
  rce_pkg::pair_t wr_data, rd_a, rd_b;
  logic           rd_en;
  logic [AW-1:0]  rd_addr_a, rd_addr_b;
  logic           rank_done;
  rce_pkg::sums_t sums;
  logic           corr_valid;
  rce_pkg::corr_t corr;

  assign accept  = in_valid_i && !in_stall_o;
  assign wr_en   = accept && (cnt_q < CW'(MAX_POINTS));
  assign cnt_inc = cnt_q + CW'(wr_en);
  assign wr_data = '{x: in_req_i.x_sample, y: in_req_i.y_sample};
  assign ld      = corr_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      n_q         <= '0;
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      start_q <= 1'b0;
      if (accept) begin
        if (in_req_i.last_pair) begin
          n_q     <= cnt_inc;
          cnt_q   <= '0;
          busy_q  <= 1'b1;
          start_q <= 1'b1;
        end else begin
          cnt_q <= cnt_inc;
        end
      end
      if (ld) begin
        out_valid_q      <= 1'b1;
        out_q.rho        <= corr.rho;
        out_q.invalid    <= corr.invalid;
        out_q.pair_count <= rce_pkg::COUNT_OUT_W'(n_q);
        busy_q           <= 1'b0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  rce_pair_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (cnt_q[AW-1:0]),
    .wr_data_i   (wr_data),
    .rd_en_i     (rd_en),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_a_o      (rd_a),
    .rd_b_o      (rd_b)
  );

  rce_rank_unit #(
    .AW (AW),
    .CW (CW)
  ) u_rank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_q),
    .n_i         (n_q),
    .rd_en_o     (rd_en),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .rd_a_i      (rd_a),
    .rd_b_i      (rd_b),
    .done_o      (rank_done),
    .sums_o      (sums)
  );

  rce_corr_unit #(
    .CW (CW)
  ) u_corr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (rank_done),
    .n_i         (n_q),
    .sums_i      (sums),
    .res_valid_o (corr_valid),
    .res_ack_i   (ld),
    .res_o       (corr)
  );

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
`default_nettype wire

// ===== rtl/core/rce_pair_mem.sv =====
// rce_pair_mem: sample pair memory, one write port and two registered read ports
// depends on rce_pkg for the word layout
`default_nettype none
module rce_pair_mem #(
  parameter int unsigned DEPTH = rce_pkg::MAX_POINTS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic           clk_i,
  input  wire logic           wr_en_i,
  input  wire logic [AW-1:0]  wr_addr_i,
  input  wire rce_pkg::pair_t wr_data_i,
  input  wire logic           rd_en_i,
  input  wire logic [AW-1:0]  rd_addr_a_i,
  input  wire logic [AW-1:0]  rd_addr_b_i,
  output rce_pkg::pair_t      rd_a_o,
  output rce_pkg::pair_t      rd_b_o
);

  rce_pkg::pair_t mem [DEPTH];
  rce_pkg::pair_t rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem[rd_addr_a_i];
      rd_b_q <= mem[rd_addr_b_i];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule
`default_nettype wire

// ===== rtl/core/rce_rank_unit.sv =====
// rce_rank_unit: quadratic ranking pass over the pair memory
// reads element i and element j each cycle, counts smaller/equal samples,
// then squares, multiplies and accumulates centered doubled ranks; depends on rce_pkg
`default_nettype none
module rce_rank_unit #(
  parameter int unsigned AW = 10,
  parameter int unsigned CW = 11
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [CW-1:0]  n_i,
  output logic                rd_en_o,
  output logic [AW-1:0]       rd_addr_a_o,
  output logic [AW-1:0]       rd_addr_b_o,
  input  wire rce_pkg::pair_t rd_a_i,
  input  wire rce_pkg::pair_t rd_b_i,
  output logic                done_o,
  output rce_pkg::sums_t      sums_o
);

  localparam int unsigned RW = CW + 2;
  localparam int unsigned PW = 2 * RW;

  typedef enum logic [1:0] {R_IDLE, R_ISSUE, R_DRAIN} state_e;

  state_e               state_q;
  logic [AW-1:0]        i_q, j_q;
  logic [CW-1:0]        n_q;
  logic                 s1_v_q, s1_last_q, s2_v_q, s3_v_q, done_q;
  logic [CW-1:0]        lx_q, ex_q, ly_q, ey_q;
  logic signed [RW-1:0] cx_q, cy_q;
  logic signed [PW-1:0] pxx_q, pyy_q, pxy_q;
  rce_pkg::sums_t       sums_q;

  logic                 i_last, j_last;
  logic [CW-1:0]        lx_tot, ex_tot, ly_tot, ey_tot;
  logic signed [RW-1:0] cx_w, cy_w;

  assign i_last = (i_q == AW'(n_q - CW'(1)));
  assign j_last = (j_q == AW'(n_q - CW'(1)));

  assign lx_tot = lx_q + CW'(rd_b_i.x < rd_a_i.x);
  assign ex_tot = ex_q + CW'(rd_b_i.x == rd_a_i.x);
  assign ly_tot = ly_q + CW'(rd_b_i.y < rd_a_i.y);
  assign ey_tot = ey_q + CW'(rd_b_i.y == rd_a_i.y);

  // equal count includes the element itself, so 2*less + eq - n is the doubled centered rank
  assign cx_w = $signed(RW'({lx_tot, 1'b0}) + RW'(ex_tot) - RW'(n_q));
  assign cy_w = $signed(RW'({ly_tot, 1'b0}) + RW'(ey_tot) - RW'(n_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= R_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      n_q       <= '0;
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      done_q    <= 1'b0;
      lx_q      <= '0;
      ex_q      <= '0;
      ly_q      <= '0;
      ey_q      <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      pxx_q     <= '0;
      pyy_q     <= '0;
      pxy_q     <= '0;
      sums_q    <= '0;
    end else begin
      done_q    <= 1'b0;
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
      case (state_q)
        R_IDLE: begin
          if (start_i) begin
            n_q     <= n_i;
            i_q     <= '0;
            j_q     <= '0;
            lx_q    <= '0;
            ex_q    <= '0;
            ly_q    <= '0;
            ey_q    <= '0;
            sums_q  <= '0;
            state_q <= R_ISSUE;
          end
        end
        R_ISSUE: begin
          s1_v_q    <= 1'b1;
          s1_last_q <= j_last;
          if (j_last) begin
            j_q <= '0;
            if (i_last) begin
              state_q <= R_DRAIN;
            end else begin
              i_q <= i_q + AW'(1);
            end
          end else begin
            j_q <= j_q + AW'(1);
          end
        end
        R_DRAIN: begin
          if (!s1_v_q && !s2_v_q && !s3_v_q) begin
            done_q  <= 1'b1;
            state_q <= R_IDLE;
          end
        end
        default: begin
          state_q <= R_IDLE;
        end
      endcase

      // compare stage
      s2_v_q <= 1'b0;
      if (s1_v_q) begin
        if (s1_last_q) begin
          cx_q   <= cx_w;
          cy_q   <= cy_w;
          s2_v_q <= 1'b1;
          lx_q   <= '0;
          ex_q   <= '0;
          ly_q   <= '0;
          ey_q   <= '0;
        end else begin
          lx_q <= lx_tot;
          ex_q <= ex_tot;
          ly_q <= ly_tot;
          ey_q <= ey_tot;
        end
      end

      // product stage
      s3_v_q <= s2_v_q;
      if (s2_v_q) begin
        pxx_q <= PW'(cx_q) * PW'(cx_q);
        pyy_q <= PW'(cy_q) * PW'(cy_q);
        pxy_q <= PW'(cx_q) * PW'(cy_q);
      end

      // accumulate stage
      if (s3_v_q) begin
        sums_q.sxx <= sums_q.sxx + rce_pkg::SUM_W'(pxx_q);
        sums_q.syy <= sums_q.syy + rce_pkg::SUM_W'(pyy_q);
        sums_q.sxy <= sums_q.sxy + rce_pkg::SUM_W'(pxy_q);
      end
    end
  end

  assign rd_en_o     = (state_q == R_ISSUE);
  assign rd_addr_a_o = i_q;
  assign rd_addr_b_o = j_q;
  assign done_o      = done_q;
  assign sums_o      = sums_q;

endmodule
`default_nettype wire

// ===== rtl/core/rce_corr_unit.sv =====
// rce_corr_unit: turns rank sums into rho in Q1.15
// 64x64 product from 32x32 partials, bit-pair square root, restoring divide,
// round half away from zero and saturate; depends on rce_pkg
`default_nettype none
module rce_corr_unit #(
  parameter int unsigned CW = 11
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [CW-1:0]  n_i,
  input  wire rce_pkg::sums_t sums_i,
  output logic                res_valid_o,
  input  wire logic           res_ack_i,
  output rce_pkg::corr_t      res_o
);

  typedef enum logic [2:0] {
    C_IDLE, C_MUL, C_MACC, C_SQRT, C_DPREP, C_DIV, C_RND, C_HOLD
  } state_e;

  state_e         state_q;
  logic [63:0]    sxx_q, syy_q, mag_q;
  logic           neg_q;
  logic [1:0]     k_q;
  logic [63:0]    prod_q;
  logic [1:0]     sh_q;
  logic [127:0]   acc_q;
  logic [67:0]    rem_q;
  logic [63:0]    root_q;
  logic [5:0]     scnt_q;
  logic [79:0]    r_q, dv_q;
  logic [16:0]    q_q;
  logic [4:0]     dcnt_q;
  rce_pkg::corr_t res_q;

  logic [31:0]    a_part, b_part;
  logic [127:0]   prod_sh;
  logic [67:0]    rem_t, trial;
  logic           sq_take, dv_take, rnd_up;
  logic [17:0]    q_r;
  logic [63:0]    sxy_mag;
  logic           ok_in;

  assign a_part = k_q[1] ? sxx_q[63:32] : sxx_q[31:0];
  assign b_part = k_q[0] ? syy_q[63:32] : syy_q[31:0];

  always_comb begin
    case (sh_q)
      2'd0:    prod_sh = {64'd0, prod_q};
      2'd1:    prod_sh = {32'd0, prod_q, 32'd0};
      2'd2:    prod_sh = {prod_q, 64'd0};
      default: prod_sh = '0;
    endcase
  end

  assign rem_t   = {rem_q[65:0], acc_q[127:126]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign sq_take = (rem_t >= trial);
  assign dv_take = (r_q >= dv_q);
  assign rnd_up  = ({r_q, 1'b0} >= {17'd0, root_q});
  assign q_r     = {1'b0, q_q} + 18'(rnd_up);

  assign sxy_mag = sums_i.sxy[63] ? (64'd0 - sums_i.sxy) : sums_i.sxy;
  assign ok_in   = (n_i >= CW'(2)) && (sums_i.sxx != '0) && (sums_i.syy != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      sxx_q   <= '0;
      syy_q   <= '0;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      k_q     <= '0;
      prod_q  <= '0;
      sh_q    <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      root_q  <= '0;
      scnt_q  <= '0;
      r_q     <= '0;
      dv_q    <= '0;
      q_q     <= '0;
      dcnt_q  <= '0;
      res_q   <= '0;
    end else begin
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            sxx_q <= sums_i.sxx;
            syy_q <= sums_i.syy;
            mag_q <= sxy_mag;
            neg_q <= sums_i.sxy[63];
            k_q   <= '0;
            acc_q <= '0;
            if (ok_in) begin
              state_q <= C_MUL;
            end else begin
              res_q.rho     <= '0;
              res_q.invalid <= 1'b1;
              state_q       <= C_HOLD;
            end
          end
        end
        C_MUL: begin
          prod_q  <= a_part * b_part;
          sh_q    <= 2'(k_q[1]) + 2'(k_q[0]);
          state_q <= C_MACC;
        end
        C_MACC: begin
          acc_q <= acc_q + prod_sh;
          if (k_q == 2'd3) begin
            rem_q   <= '0;
            root_q  <= '0;
            scnt_q  <= '0;
            state_q <= C_SQRT;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= C_MUL;
          end
        end
        C_SQRT: begin
          // two radicand bits per step, one root bit
          acc_q  <= {acc_q[125:0], 2'b00};
          rem_q  <= sq_take ? (rem_t - trial) : rem_t;
          root_q <= {root_q[62:0], sq_take};
          scnt_q <= scnt_q + 6'd1;
          if (scnt_q == 6'd63) begin
            state_q <= C_DPREP;
          end
        end
        C_DPREP: begin
          r_q     <= {1'b0, mag_q, 15'd0};
          dv_q    <= {root_q, 16'd0};
          q_q     <= '0;
          dcnt_q  <= '0;
          state_q <= C_DIV;
        end
        C_DIV: begin
          if (dv_take) begin
            r_q <= r_q - dv_q;
          end
          q_q    <= {q_q[15:0], dv_take};
          dv_q   <= {1'b0, dv_q[79:1]};
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'd16) begin
            state_q <= C_RND;
          end
        end
        C_RND: begin
          res_q.invalid <= 1'b0;
          if (neg_q) begin
            res_q.rho <= (q_r > 18'd32768) ? 16'sh8000 : 16'(18'd0 - q_r);
          end else begin
            res_q.rho <= (q_r > 18'd32767) ? 16'sh7fff : 16'(q_r);
          end
          state_q <= C_HOLD;
        end
        C_HOLD: begin
          if (res_ack_i) begin
            state_q <= C_IDLE;
          end
        end
        default: begin
          state_q <= C_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = (state_q == C_HOLD);
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ===== rtl/core/rce_checker.sv =====
// rce_checker: port-level assertions for rank_correlation_engine_unit
// bound to the top level below; depends on rce_pkg
`default_nettype none
module rce_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire rce_pkg::req_t in_req_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire rce_pkg::rsp_t out_rsp_o
);

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("result changed while stalled");

  // closing pair blocks further requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_req_i.last_pair) |=> in_stall_o)
    else $error("request taken after closing pair");

  // invalid result carries zero rho
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.invalid) |-> (out_rsp_o.rho == '0))
    else $error("invalid result with nonzero rho");

  // a new result only appears at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a closed set");

endmodule

bind rank_correlation_engine_unit rce_checker u_rce_checker (.*);
`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking testbench for rank_correlation_engine_unit
// predicts spearman rho per closed set and compares each result in order
// depends on rce_pkg and the rtl of the engine
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPTS = 1024;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rce_pkg::req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rce_pkg::rsp_t out_rsp;

  rank_correlation_engine_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // pending requests and expected rho results
  rce_pkg::req_t pending_reqs[$];
  rce_pkg::rsp_t expected_rho[$];

  // predictor state
  logic signed [31:0] xs[NPTS];
  logic signed [31:0] ys[NPTS];
  int unsigned held_pairs = 0;
  int unsigned sets_closed = 0;
  int unsigned invalid_sets = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  bit drive_busy_free = 1'b0;
  bit recv_busy_free = 1'b0;
  int unsigned hold_cycles = 0;
  bit stim_done = 1'b0;

  function automatic longint doubled_rank(ref logic signed [31:0] v[NPTS], input int n,
                                          input int i);
    longint less;
    longint eq;
    less = 0;
    eq = 0;
    for (int j = 0; j < n; j++) begin
      if (j != i) begin
        if (v[j] < v[i]) less++;
        else if (v[j] == v[i]) eq++;
      end
    end
    return 2 + 2 * less + eq - (longint'(n) + 1);
  endfunction

  function automatic logic [63:0] wide_isqrt(logic [127:0] p);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= p) res = cand;
    end
    return res;
  endfunction

  function automatic rce_pkg::rsp_t spearman_of_set(int n);
    rce_pkg::rsp_t r;
    longint cx, cy;
    logic [63:0] sxx, syy, sxy, s, mag, q, rem;
    logic [127:0] num;
    r = '0;
    r.invalid = 1'b1;
    r.pair_count = n[10:0];
    sxx = '0;
    syy = '0;
    sxy = '0;
    for (int i = 0; i < n; i++) begin
      cx = doubled_rank(xs, n, i);
      cy = doubled_rank(ys, n, i);
      sxx += cx * cx;
      syy += cy * cy;
      sxy += cx * cy;
    end
    if (n >= 2 && sxx != 0 && syy != 0) begin
      s = wide_isqrt({64'd0, sxx} * {64'd0, syy});
      mag = sxy[63] ? -sxy : sxy;
      num = {64'd0, mag} << 15;
      q = num / s;
      rem = num % s;
      if ({rem, 1'b0} >= {1'b0, s}) q++;
      if (sxy[63]) begin
        if (q > 32768) q = 32768;
        r.rho = -q[15:0];
      end else begin
        if (q > 32767) q = 32767;
        r.rho = q[15:0];
      end
      r.invalid = 1'b0;
    end
    return r;
  endfunction

  task automatic predict_pair(rce_pkg::req_t rq);
    if (held_pairs < NPTS) begin
      xs[held_pairs] = rq.x_sample;
      ys[held_pairs] = rq.y_sample;
      held_pairs++;
    end
    if (rq.last_pair) begin
      expected_rho.push_back(spearman_of_set(held_pairs));
      sets_closed++;
      if (expected_rho[$].invalid) invalid_sets++;
      held_pairs = 0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_pair(in_req);
        void'(pending_reqs.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (pending_reqs.size() > 0
                   && (drive_busy_free || $urandom_range(99) >= 34)) begin
        in_valid <= 1'b1;
        in_req <= pending_reqs[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_rho.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_rsp);
        end else begin
          if (out_rsp.rho !== expected_rho[0].rho
              || out_rsp.invalid !== expected_rho[0].invalid
              || out_rsp.pair_count !== expected_rho[0].pair_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected rho %0d inv %0b n %0d, got rho %0d inv %0b n %0d",
                       expected_rho[0].rho, expected_rho[0].invalid,
                       expected_rho[0].pair_count, out_rsp.rho, out_rsp.invalid,
                       out_rsp.pair_count);
          end
          void'(expected_rho.pop_front());
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !recv_busy_free && $urandom_range(99) < 34;
      end
    end
  end

  function automatic logic signed [31:0] pick_sample(int mode);
    case (mode)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(7))) - 3;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic queue_set(int n, int xmode, int ymode);
    rce_pkg::req_t rq;
    for (int i = 0; i < n; i++) begin
      rq.x_sample = pick_sample(xmode == 4 ? $urandom_range(3) : xmode);
      rq.y_sample = pick_sample(ymode == 4 ? $urandom_range(3) : ymode);
      rq.last_pair = (i == n - 1);
      pending_reqs.push_back(rq);
    end
  endtask

  initial begin
    int queued;
    int n;
    bit pressed;
    bit free_done;
    rce_pkg::req_t rq;
    pressed = 1'b0;
    free_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // directed: single pair, extremes, all ties, perfect order and reverse
    queue_set(1, 0, 1);
    queue_set(2, 0, 1);
    rq = '{x_sample: 32'sh8000_0000, y_sample: 32'sh7fff_ffff, last_pair: 1'b0};
    pending_reqs.push_back(rq);
    rq = '{x_sample: 32'sh7fff_ffff, y_sample: 32'sh8000_0000, last_pair: 1'b1};
    pending_reqs.push_back(rq);
    queue_set(4, 1, 3);
    for (int i = 0; i < 5; i++) begin
      rq = '{x_sample: i, y_sample: i * 7 - 9, last_pair: i == 4};
      pending_reqs.push_back(rq);
    end
    for (int i = 0; i < 4; i++) begin
      rq = '{x_sample: i, y_sample: -i, last_pair: i == 3};
      pending_reqs.push_back(rq);
    end
    queue_set(5, 2, 2);
    // random sets, small mostly
    queued = 23;
    while (queued < 420) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 2) : $urandom_range(12, 1);
      queue_set(n, $urandom_range(4), $urandom_range(4));
      queued += n;
      if (!pressed && queued > 120) begin
        // receiver holds off while sets keep arriving
        wait (pending_reqs.size() < 20);
        hold_cycles = 400;
        pressed = 1'b1;
      end
      if (!free_done && !drive_busy_free && queued > 220) begin
        wait (pending_reqs.size() < 20);
        drive_busy_free = 1'b1;
        recv_busy_free = 1'b1;
      end
      if (drive_busy_free && queued > 330) begin
        wait (pending_reqs.size() < 20);
        drive_busy_free = 1'b0;
        recv_busy_free = 1'b0;
        free_done = 1'b1;
      end
    end
    // a full store plus overflow pairs, closing after the store is full
    queue_set(1030, 3, 3);
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_rho.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d sets (%0d invalid), %0d results checked, up to a full store",
             sets_closed, invalid_sets, results_seen);
    if (mismatches == 0 && expected_rho.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
